// ===== rtl/lprd_pkg.sv =====
`default_nettype none

package lprd_pkg;

  // Every length and count field on the wire is four bytes, little-endian.
  localparam int unsigned FieldBytes = 4;
  localparam logic [31:0] MinReqLen  = 32'(FieldBytes);

  typedef enum logic [2:0] {
    PH_REQLEN = 3'd0,
    PH_COUNT  = 3'd1,
    PH_STRLEN = 3'd2,
    PH_DATA   = 3'd3,
    PH_CLOSED = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_REQLEN  = 3'd0,
    ROLE_COUNT   = 3'd1,
    ROLE_STRLEN  = 3'd2,
    ROLE_DATA    = 3'd3,
    ROLE_DISCARD = 3'd4
  } role_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TOO_LONG = 3'd1,
    ERR_COUNT    = 3'd2,
    ERR_OVERRUN  = 3'd3,
    ERR_TRAILING = 3'd4
  } err_e;

  typedef struct packed {
    role_e       role;
    logic [7:0]  data_byte;
    logic [31:0] string_index;
    logic        last_of_string;
    logic        empty_string;
    logic        request_done;
    err_e        error_code;
    logic        closed;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/length_prefixed_request_deframer.sv =====
// The result of a request byte is captured in the output register when the byte is accepted.
// Throughput: one byte per cycle while m_axis_tready does not stall the output; the only
// loop is the per-byte parse state, which is updated by compares and decrements.
// Reset: rst_ni is asynchronous and active low; it empties the output register,
// returns the parser to the request length field, reopens the link and sets max_msg to 4096.
`default_nettype none

module length_prefixed_request_deframer
  import lprd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] data_byte, [39:8] string_index, [40] last_of_string, [41] empty_string,
  // [44:42] error_code, [45] closed, [47:46] zero
  output logic [47:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,   // [2:0] role
  output logic             m_axis_tlast,   // request_done

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration register.
  logic [31:0] max_msg_q;
  logic        cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == 1'b0);
  assign prdata  = cfg_sel ? max_msg_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_q <= 32'd4096;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      max_msg_q <= pwdata;
    end
  end

  // Parser state.
  phase_e           phase_q, phase_d;
  logic [1:0]       fbc_q, fbc_d;
  logic [2:0][7:0]  fs_q, fs_d;
  logic [31:0]      rbl_q, rbl_d;
  logic [31:0]      sl_q, sl_d;
  logic [31:0]      sbl_q, sbl_d;
  logic [31:0]      cs_q, cs_d;
  logic             closed_q, closed_d;

  logic             in_accept;
  logic [7:0]       b;

  assign b         = s_axis_tdata;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Evaluation of the current request byte.
  logic        fdone;
  logic [31:0] v;
  logic [31:0] rbl_dec;
  logic [31:0] sl_dec;
  logic        chk_after;
  logic [31:0] as_sl;
  logic        ev_last, ev_empty, ev_done, ev_to_strlen, ev_to_data;
  err_e        ev_err;

  assign fdone   = (fbc_q == 2'd3);
  assign v       = {b, fs_q[2], fs_q[1], fs_q[0]};
  assign rbl_dec = rbl_q - 32'd1;
  assign sl_dec  = sl_q - 32'd1;

  always_comb begin
    ev_err       = ERR_NONE;
    ev_last      = 1'b0;
    ev_empty     = 1'b0;
    ev_done      = 1'b0;
    ev_to_strlen = 1'b0;
    ev_to_data   = 1'b0;
    chk_after    = 1'b0;
    as_sl        = sl_dec;
    unique case (phase_q)
      PH_REQLEN: begin
        if (fdone) begin
          if (v > max_msg_q) begin
            ev_err = ERR_TOO_LONG;
          end else if (v < MinReqLen) begin
            ev_err = ERR_OVERRUN;
          end
        end
      end
      PH_COUNT: begin
        if (fdone) begin
          if (v > max_msg_q) begin
            ev_err = ERR_COUNT;
          end else begin
            as_sl     = v;
            chk_after = 1'b1;
          end
        end
      end
      PH_STRLEN: begin
        if (fdone) begin
          if (v > rbl_dec) begin
            ev_err = ERR_OVERRUN;
          end else if (v == 32'd0) begin
            ev_last   = 1'b1;
            ev_empty  = 1'b1;
            chk_after = 1'b1;
          end else begin
            ev_to_data = 1'b1;
          end
        end
      end
      PH_DATA: begin
        if (sbl_q == 32'd1) begin
          ev_last   = 1'b1;
          chk_after = 1'b1;
        end
      end
      default: ;
    endcase

    // After a completed string or count: either the request ends exactly here,
    // or another full string length must still fit.
    if (chk_after) begin
      if (as_sl == 32'd0) begin
        if (rbl_dec != 32'd0) begin
          ev_err = ERR_TRAILING;
        end else begin
          ev_done = 1'b1;
        end
      end else if (rbl_dec < MinReqLen) begin
        ev_err = ERR_OVERRUN;
      end else begin
        ev_to_strlen = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    phase_d  = phase_q;
    fbc_d    = fbc_q;
    fs_d     = fs_q;
    rbl_d    = rbl_q;
    sl_d     = sl_q;
    sbl_d    = sbl_q;
    cs_d     = cs_q;
    closed_d = closed_q;

    if (phase_q == PH_REQLEN || phase_q == PH_COUNT || phase_q == PH_STRLEN) begin
      fbc_d = fbc_q + 2'd1;
      case (fbc_q)
        2'd0:    fs_d[0] = b;
        2'd1:    fs_d[1] = b;
        2'd2:    fs_d[2] = b;
        default: ;
      endcase
    end

    unique case (phase_q)
      PH_REQLEN: begin
        if (fdone) begin
          rbl_d   = v;
          cs_d    = 32'd0;
          phase_d = PH_COUNT;
        end
      end
      PH_COUNT: begin
        rbl_d = rbl_dec;
        if (fdone) begin
          sl_d = v;
        end
      end
      PH_STRLEN: begin
        rbl_d = rbl_dec;
        if (ev_to_data) begin
          sbl_d   = v;
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        rbl_d = rbl_dec;
        sbl_d = sbl_q - 32'd1;
      end
      default: begin
        phase_d  = PH_CLOSED;
        closed_d = 1'b1;
      end
    endcase

    if (ev_last) begin
      sl_d = sl_dec;
      cs_d = cs_q + 32'd1;
    end
    if (ev_to_strlen) begin
      phase_d = PH_STRLEN;
    end
    if (ev_done) begin
      phase_d = PH_REQLEN;
      cs_d    = 32'd0;
    end
    if (ev_err != ERR_NONE) begin
      phase_d  = PH_CLOSED;
      closed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_REQLEN;
      fbc_q    <= 2'd0;
      fs_q     <= '0;
      rbl_q    <= 32'd0;
      sl_q     <= 32'd0;
      sbl_q    <= 32'd0;
      cs_q     <= 32'd0;
      closed_q <= 1'b0;
    end else if (in_accept) begin
      phase_q  <= phase_d;
      fbc_q    <= fbc_d;
      fs_q     <= fs_d;
      rbl_q    <= rbl_d;
      sl_q     <= sl_d;
      sbl_q    <= sbl_d;
      cs_q     <= cs_d;
      closed_q <= closed_d;
    end
  end

  // Result of the current byte.
  result_t res_d, res_q;
  logic    out_valid_q;

  always_comb begin
    res_d                = '0;
    res_d.data_byte      = b;
    res_d.last_of_string = ev_last;
    res_d.empty_string   = ev_empty;
    res_d.request_done   = ev_done;
    res_d.error_code     = ev_err;
    res_d.closed         = closed_d;
    unique case (phase_q)
      PH_REQLEN: res_d.role = ROLE_REQLEN;
      PH_COUNT:  res_d.role = ROLE_COUNT;
      PH_STRLEN: begin
        res_d.role         = ROLE_STRLEN;
        res_d.string_index = cs_q;
      end
      PH_DATA: begin
        res_d.role         = ROLE_DATA;
        res_d.string_index = cs_q;
      end
      default: res_d.role  = ROLE_DISCARD;
    endcase
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.role;
  assign m_axis_tlast  = res_q.request_done;
  assign m_axis_tdata  = {2'b00, res_q.closed, res_q.error_code, res_q.empty_string,
                          res_q.last_of_string, res_q.string_index, res_q.data_byte};

`ifndef SYNTHESIS
  // Once closed, the link stays closed until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q)
    else $error("closed link reopened");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CLOSED) == closed_q)
    else $error("parse phase and closed flag disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.error_code != ERR_NONE) |-> res_q.closed)
    else $error("error reported without closing the link");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.request_done) |->
      (res_q.error_code == ERR_NONE && !res_q.closed &&
       (res_q.role == ROLE_COUNT || res_q.role == ROLE_STRLEN ||
        res_q.role == ROLE_DATA)))
    else $error("request completion on an invalid byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.role == ROLE_DISCARD) |->
      (res_q.closed && res_q.error_code == ERR_NONE && !res_q.last_of_string))
    else $error("discarded byte carries parse results");
`endif

endmodule

`default_nettype wire
